>>> design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/lstrm_pkg.sv
// ----------------------------------------------------------------------------
// lstrm_pkg
// Types, codes and node update functions of the lazy range max tree.
// ----------------------------------------------------------------------------
package lstrm_pkg;

  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_ASSIGN = 2'd1;
  localparam logic [1:0] MODE_ADD    = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // -1000000000
  localparam logic [31:0] NEG_FILL = 32'hC4653600;

  localparam logic [1:0] SEL_NODE  = 2'd0;
  localparam logic [1:0] SEL_LEFT  = 2'd1;
  localparam logic [1:0] SEL_RIGHT = 2'd2;

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] asg;
    logic        asg_v;
    logic [31:0] add;
  } node_t;

  localparam node_t CLEAR_NODE = '{mx: NEG_FILL, asg: 32'd0, asg_v: 1'b0, add: 32'd0};

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       do_apply;
    logic       do_push;
    logic       do_fix;
    logic       ret_neg;
    logic       ret_node;
    logic       ret_final;
    logic       go_left;
    logic       go_right;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       disjoint;
    logic       covered;
    logic       phase;
    logic       empty;
    logic       clr_last;
    logic [1:0] op;
  } status_t;

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic node_t do_assign(input node_t n, input logic [31:0] x);
    node_t r;
    r = n;
    r.mx = x;
    r.asg = x;
    r.asg_v = 1'b1;
    r.add = 32'd0;
    return r;
  endfunction

  function automatic node_t do_add(input node_t n, input logic [31:0] x);
    node_t r;
    r = n;
    if (n.asg_v) begin
      r.asg = n.asg + x;
    end else begin
      r.add = n.add + x;
    end
    r.mx = n.mx + x;
    return r;
  endfunction

  function automatic node_t apply_op(input logic [1:0] op, input logic [31:0] x,
                                     input node_t n);
    node_t r;
    r = n;
    if (op == MODE_ASSIGN) begin
      r = do_assign(n, x);
    end else if (op == MODE_ADD) begin
      r = do_add(n, x);
    end
    return r;
  endfunction

  // child after the parent's pending work moves down
  function automatic node_t push_child(input node_t p, input node_t c);
    node_t r;
    r = c;
    if (p.asg_v) begin
      r = do_assign(c, p.asg);
    end else if (p.add != 32'd0) begin
      r = do_add(c, p.add);
    end
    return r;
  endfunction

  function automatic node_t push_clear(input node_t p);
    node_t r;
    r = p;
    if (p.asg_v) begin
      r.asg_v = 1'b0;
    end else begin
      r.add = 32'd0;
    end
    return r;
  endfunction

endpackage

>>> design/lstrm_dp.sv
// ----------------------------------------------------------------------------
// lstrm_dp
// Node memory, walk stack, working node registers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lstrm_dp import lstrm_pkg::*; #(
  parameter int TREE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [1:0]  mode,
  input  logic [10:0] range_start,
  input  logic [10:0] range_end,
  input  logic [31:0] operand_value,
  output status_t     st,
  output logic [31:0] max_value
);

  localparam int NODE_CNT = 4 * TREE_SIZE;
  localparam int NW = $clog2(NODE_CNT);
  localparam int IW = $clog2(TREE_SIZE + 1);
  localparam int CW = (IW > 11) ? IW : 11;
  localparam int SDEPTH = $clog2(TREE_SIZE) + 2;
  localparam int PW = $clog2(SDEPTH + 1);
  localparam int TW = $clog2(SDEPTH);

  logic [1:0]    op;
  logic [CW-1:0] s_q;
  logic [CW-1:0] e_q;
  logic [31:0]   x_q;

  logic [NW-1:0] stk_node [SDEPTH];
  logic [IW-1:0] stk_lo [SDEPTH];
  logic [IW-1:0] stk_hi [SDEPTH];
  logic          stk_ph [SDEPTH];
  logic [31:0]   stk_acc [SDEPTH];
  logic [PW-1:0] sp;

  logic [PW-1:0] sp_m1;
  logic [TW-1:0] top;
  logic [TW-1:0] nxt;
  logic [NW-1:0] t_node;
  logic [IW-1:0] t_lo;
  logic [IW-1:0] t_hi;
  logic [IW-1:0] mid;
  logic [NW-1:0] lnode;
  logic [NW-1:0] rnode;
  logic [CW-1:0] lo_x;
  logic [CW-1:0] hi_x;
  logic          pop;

  node_t         nd;
  node_t         lf;
  node_t         rt;
  logic [31:0]   ret;

  node_t         mem [NODE_CNT];
  node_t         mem_q;
  logic [NW-1:0] clr_cnt;
  logic [NW-1:0] rd_addr;
  logic [NW-1:0] wr_addr;
  node_t         wr_data;

  assign sp_m1  = sp - 1'b1;
  assign top    = sp_m1[TW-1:0];
  assign nxt    = sp[TW-1:0];
  assign t_node = stk_node[top];
  assign t_lo   = stk_lo[top];
  assign t_hi   = stk_hi[top];
  assign mid    = t_lo + ((t_hi - t_lo) >> 1);
  assign lnode  = {t_node[NW-2:0], 1'b0};
  assign rnode  = {t_node[NW-2:0], 1'b1};
  assign lo_x   = CW'(t_lo);
  assign hi_x   = CW'(t_hi);
  assign pop    = cmd.ret_neg | cmd.ret_node | cmd.ret_final;

  assign st.disjoint = (e_q <= lo_x) || (hi_x <= s_q);
  assign st.covered  = (s_q <= lo_x) && (hi_x <= e_q);
  assign st.phase    = stk_ph[top];
  assign st.empty    = (sp == '0);
  assign st.clr_last = (clr_cnt == NW'(NODE_CNT - 1));
  assign st.op       = op;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= mode;
      s_q <= CW'(range_start);
      e_q <= CW'(range_end);
      x_q <= operand_value;
    end
  end

  // walk stack, one frame per tree level
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      if (cmd.load) begin
        stk_node[0] <= NW'(1);
        stk_lo[0]   <= '0;
        stk_hi[0]   <= IW'(TREE_SIZE);
        stk_ph[0]   <= 1'b0;
        sp          <= PW'(1);
      end
      if (cmd.go_left) begin
        stk_node[nxt] <= lnode;
        stk_lo[nxt]   <= t_lo;
        stk_hi[nxt]   <= mid;
        stk_ph[nxt]   <= 1'b0;
        sp            <= sp + 1'b1;
      end
      if (cmd.go_right) begin
        stk_acc[top]  <= ret;
        stk_ph[top]   <= 1'b1;
        stk_node[nxt] <= rnode;
        stk_lo[nxt]   <= mid;
        stk_hi[nxt]   <= t_hi;
        stk_ph[nxt]   <= 1'b0;
        sp            <= sp + 1'b1;
      end
      if (pop) begin
        sp <= sp_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        SEL_NODE:  nd <= mem_q;
        SEL_LEFT:  lf <= mem_q;
        SEL_RIGHT: rt <= mem_q;
        default:   nd <= mem_q;
      endcase
    end
    if (cmd.do_apply) begin
      nd <= apply_op(op, x_q, nd);
    end
    if (cmd.do_push) begin
      lf <= push_child(nd, lf);
      rt <= push_child(nd, rt);
      nd <= push_clear(nd);
    end
    if (cmd.do_fix) begin
      nd.mx <= smax(lf.mx, rt.mx);
    end
    if (cmd.ret_neg) begin
      ret <= NEG_FILL;
    end else if (cmd.ret_node) begin
      ret <= nd.mx;
    end else if (cmd.ret_final) begin
      ret <= smax(stk_acc[top], ret);
    end
    if (cmd.out_load) begin
      max_value <= ret;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      SEL_NODE:  rd_addr = t_node;
      SEL_LEFT:  rd_addr = lnode;
      SEL_RIGHT: rd_addr = rnode;
      default:   rd_addr = t_node;
    endcase
  end

  always_comb begin
    wr_addr = t_node;
    wr_data = nd;
    if (cmd.clr_wr) begin
      wr_addr = clr_cnt;
      wr_data = CLEAR_NODE;
    end else begin
      case (cmd.wr_sel)
        SEL_NODE: begin
          wr_addr = t_node;
          wr_data = nd;
        end
        SEL_LEFT: begin
          wr_addr = lnode;
          wr_data = lf;
        end
        SEL_RIGHT: begin
          wr_addr = rnode;
          wr_data = rt;
        end
        default: begin
          wr_addr = t_node;
          wr_data = nd;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en || cmd.clr_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  `ASSERT_IMP(a_stack_room, clk, rst, cmd.go_left || cmd.go_right, sp < PW'(SDEPTH))
  `ASSERT_IMP(a_pop_nonempty, clk, rst, pop, sp != '0)

endmodule

>>> design/lstrm_ctrl.sv
// ----------------------------------------------------------------------------
// lstrm_ctrl
// Sequencer for the tree walk: clear pass, node visits, push-down, fix-up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lstrm_ctrl import lstrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] mode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  status_t    st,
  output cmd_t       cmd
);

  localparam logic [4:0] ST_CLEAR  = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_ENTER  = 5'd2;
  localparam logic [4:0] ST_NCAP   = 5'd3;
  localparam logic [4:0] ST_LCAP   = 5'd4;
  localparam logic [4:0] ST_RCAP   = 5'd5;
  localparam logic [4:0] ST_PUSH   = 5'd6;
  localparam logic [4:0] ST_WL     = 5'd7;
  localparam logic [4:0] ST_WR     = 5'd8;
  localparam logic [4:0] ST_WN     = 5'd9;
  localparam logic [4:0] ST_APPLY  = 5'd10;
  localparam logic [4:0] ST_AWR    = 5'd11;
  localparam logic [4:0] ST_RET    = 5'd12;
  localparam logic [4:0] ST_FCN    = 5'd13;
  localparam logic [4:0] ST_FCL    = 5'd14;
  localparam logic [4:0] ST_FCR    = 5'd15;
  localparam logic [4:0] ST_FFIX   = 5'd16;
  localparam logic [4:0] ST_FWR    = 5'd17;
  localparam logic [4:0] ST_FINISH = 5'd18;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // unused mode code is taken and dropped
        if (in_valid && mode != MODE_NONE) begin
          cmd.load = 1'b1;
          state_next = ST_ENTER;
        end
      end
      ST_ENTER: begin
        if (st.disjoint) begin
          cmd.ret_neg = 1'b1;
          state_next = ST_RET;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_NODE;
          state_next = ST_NCAP;
        end
      end
      ST_NCAP: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = SEL_NODE;
        if (st.covered) begin
          state_next = ST_APPLY;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_LEFT;
          state_next = ST_LCAP;
        end
      end
      ST_LCAP: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = SEL_LEFT;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = SEL_RIGHT;
        state_next = ST_RCAP;
      end
      ST_RCAP: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = SEL_RIGHT;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        cmd.do_push = 1'b1;
        state_next = ST_WL;
      end
      ST_WL: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_LEFT;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_RIGHT;
        state_next = ST_WN;
      end
      ST_WN: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_NODE;
        cmd.go_left = 1'b1;
        state_next = ST_ENTER;
      end
      ST_APPLY: begin
        cmd.do_apply = 1'b1;
        state_next = ST_AWR;
      end
      ST_AWR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_NODE;
        cmd.ret_node = 1'b1;
        state_next = ST_RET;
      end
      ST_RET: begin
        if (st.empty) begin
          state_next = ST_FINISH;
        end else if (!st.phase) begin
          cmd.go_right = 1'b1;
          state_next = ST_ENTER;
        end else if (st.op == MODE_QUERY) begin
          cmd.ret_final = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = SEL_NODE;
          state_next = ST_FCN;
        end
      end
      ST_FCN: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = SEL_NODE;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = SEL_LEFT;
        state_next = ST_FCL;
      end
      ST_FCL: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = SEL_LEFT;
        cmd.rd_en = 1'b1;
        cmd.rd_sel = SEL_RIGHT;
        state_next = ST_FCR;
      end
      ST_FCR: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = SEL_RIGHT;
        state_next = ST_FFIX;
      end
      ST_FFIX: begin
        cmd.do_fix = 1'b1;
        state_next = ST_FWR;
      end
      ST_FWR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_sel = SEL_NODE;
        cmd.ret_final = 1'b1;
        state_next = ST_RET;
      end
      ST_FINISH: begin
        if (st.op != MODE_QUERY) begin
          state_next = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NXT(a_update_no_word, clk, rst, state == ST_FINISH && st.op != MODE_QUERY, !$rose(out_valid))
  `ASSERT_NXT(a_query_word, clk, rst, cmd.out_load, out_valid && state == ST_IDLE)

endmodule

>>> design/lazy_segment_tree_range_max_top.sv
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_max_top
// Range assign, range add and range max query over a lazy segment tree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: mode, range_start,
//   range_end, operand_value. Mode 0 queries the max of [start, end),
//   mode 1 assigns, mode 2 adds; mode 3 is taken and dropped.
//   Output channel (out_valid/out_ready) gives one max_value word per query.
//   The walk visits each touched node through one memory port: a node
//   wholly outside the range is only checked, one wholly inside is read,
//   updated and written back, and a split node has its children read and
//   its pending work pushed down, plus a fix-up on updates. At most two
//   split and two whole nodes are visited per level; the walk takes one
//   word at a time.
//   After reset all 4*TREE_SIZE node entries are swept, with
//   in_ready low. A finished query waits in the output register while
//   out_ready is low; the next word is taken then, but its own result
//   holds until the output register is free.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_max_top import lstrm_pkg::*; #(
  parameter int TREE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [10:0] range_start,
  input  logic [10:0] range_end,
  input  logic [31:0] operand_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] max_value
);

  cmd_t    cmd;
  status_t st;

  lstrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  lstrm_dp #(
    .TREE_SIZE (TREE_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (mode),
    .range_start   (range_start),
    .range_end     (range_end),
    .operand_value (operand_value),
    .st            (st),
    .max_value     (max_value)
  );

endmodule
